FILE: rtl/tcg_pkg.sv
// shared types and constants for the text console glyph writer
// no dependencies

package tcg_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_LAYOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LAYOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LAYOUT  = 3'd6;

    // pixel modes
    localparam logic [1:0] MODE_16BPP = 2'd1;
    localparam logic [1:0] MODE_32BPP = 2'd2;

    // special character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    localparam logic [7:0]  FG_LEVEL      = 8'hc0;
    localparam logic [11:0] ROW_MAX       = 12'hfff;
    localparam logic [9:0]  COLUMNS_RESET = 10'd80;

    // glyph row index as carried between the blocks
    localparam int ROW_IDX_W = 4;

    typedef struct packed {
        logic                 load;        // store one font byte
        logic                 newline;     // cursor to next text row
        logic                 tab;         // cursor to next tab stop
        logic                 capture;     // latch character and pixel value
        logic                 mul;         // text row times line stride
        logic                 base;        // form address of first glyph row
        logic                 issue;       // read one glyph row into the pipe
        logic [ROW_IDX_W-1:0] row;         // glyph row being issued
        logic                 last;        // issued row is the final one
        logic                 cursor_step; // advance cursor after drawing
    } tcg_cmd_t;

    typedef struct packed {
        logic is_newline;
        logic is_tab;
        logic draw;     // printable character in a drawing mode
        logic advance;  // output pipe can move this cycle
    } tcg_stat_t;

endpackage

FILE: rtl/tcg_ctrl.sv
// sequencer for the glyph writer: input handshake and per-row command stream
// depends on tcg_pkg

module tcg_ctrl import tcg_pkg::*; #(
    parameter int GLYPH_ROWS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_command,
    output logic      s_ready,
    input  tcg_stat_t stat,
    output tcg_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_BASE = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(GLYPH_ROWS - 1);

    logic [1:0]           state_reg, state_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic                 accept;
    logic                 is_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_last = (row_reg == LAST_ROW);

    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        cmd             = '0;
        cmd.row         = row_reg;
        cmd.last        = is_last;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (!s_command) begin
                        cmd.load = 1'b1;
                    end else if (stat.is_newline) begin
                        cmd.newline = 1'b1;
                    end else if (stat.is_tab) begin
                        cmd.tab = 1'b1;
                    end else if (stat.draw) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL;
                    end else begin
                        // nul, or nothing to draw: no command
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.base   = 1'b1;
                row_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (stat.advance) begin
                    cmd.issue = 1'b1;
                    row_next  = row_reg + 1'b1;
                    if (is_last) begin
                        cmd.cursor_step = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule

FILE: rtl/tcg_datapath.sv
// glyph writer datapath: config registers, cursor, font memory, address math
// and the two-stage output pipe; depends on tcg_pkg

module tcg_datapath import tcg_pkg::*; #(
    parameter int GLYPH_ROWS = 16,
    parameter int FONT_CHARS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcg_cmd_t             cmd,
    output tcg_stat_t            stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_command,
    input  logic [7:0]           s_char_code,
    input  logic [3:0]           s_font_row,
    input  logic [7:0]           s_font_bits,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [31:0]          m_row_address,
    output logic [7:0]           m_glyph_bits,
    output logic [31:0]          m_pixel_value,
    output logic                 m_last_row
);

    localparam int RW    = $clog2(GLYPH_ROWS);
    localparam int CW    = $clog2(FONT_CHARS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = FONT_CHARS * (2 ** RW);

    // configuration
    logic [31:0] frame_base_reg;
    logic [15:0] line_bytes_reg;
    logic [9:0]  columns_reg;
    logic [1:0]  pixel_mode_reg;
    logic [8:0]  red_layout_reg, green_layout_reg, blue_layout_reg;

    // cursor
    logic [9:0]  cursor_col_reg;
    logic [11:0] cursor_row_reg;

    // print context
    logic [7:0]  code_reg;
    logic        code_oor_reg;
    logic [31:0] pix_reg;
    logic [27:0] prod_reg;
    logic [31:0] addr_reg;

    // pipe stage one (font read in flight) and output register
    logic        s1_valid_reg;
    logic [31:0] s1_addr_reg;
    logic        s1_last_reg;
    logic        s1_oor_reg;
    logic [7:0]  mem_q;
    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    logic [7:0]  out_bits_reg;
    logic [31:0] out_pix_reg;
    logic        out_last_reg;

    logic [7:0]  font_mem [DEPTH];

    logic          adv;
    logic          drawing_mode;
    logic          load_ok;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [10:0]   tab_col, inc_col;
    logic [11:0]   row_inc;
    logic [31:0]   cell_off;
    logic [31:0]   pix_calc;

    function automatic logic [15:0] chan16(input logic [8:0] layout);
        logic [3:0]  size;
        logic [7:0]  v;
        logic [31:0] sh;
        size = (layout[8:5] > 4'd8) ? 4'd8 : layout[8:5];
        v    = FG_LEVEL >> (4'd8 - size);
        sh   = 32'(v) << layout[4:0];
        return sh[15:0];
    endfunction

    function automatic logic [31:0] chan32(input logic [8:0] layout);
        return 32'(FG_LEVEL) << layout[4:0];
    endfunction

    assign adv          = !out_valid_reg || m_ready;
    assign drawing_mode = (pixel_mode_reg == MODE_16BPP) || (pixel_mode_reg == MODE_32BPP);

    assign stat.is_newline = (s_char_code == CH_NEWLINE);
    assign stat.is_tab     = (s_char_code == CH_TAB);
    assign stat.draw       = s_command && (s_char_code != CH_NUL) && drawing_mode;
    assign stat.advance    = adv;

    assign pix_calc = (pixel_mode_reg == MODE_16BPP)
                    ? 32'(chan16(red_layout_reg) | chan16(green_layout_reg)
                          | chan16(blue_layout_reg))
                    : (chan32(red_layout_reg) | chan32(green_layout_reg)
                       | chan32(blue_layout_reg));

    assign cell_off = (pixel_mode_reg == MODE_32BPP) ? {17'd0, cursor_col_reg, 5'd0}
                                                     : {18'd0, cursor_col_reg, 4'd0};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg   <= '0;
            line_bytes_reg   <= '0;
            columns_reg      <= COLUMNS_RESET;
            pixel_mode_reg   <= '0;
            red_layout_reg   <= '0;
            green_layout_reg <= '0;
            blue_layout_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_BASE:   frame_base_reg   <= cfg_wdata;
                REG_LINE_BYTES:   line_bytes_reg   <= cfg_wdata[15:0];
                REG_COLUMNS:      columns_reg      <= cfg_wdata[9:0];
                REG_PIXEL_MODE:   pixel_mode_reg   <= cfg_wdata[1:0];
                REG_RED_LAYOUT:   red_layout_reg   <= cfg_wdata[8:0];
                REG_GREEN_LAYOUT: green_layout_reg <= cfg_wdata[8:0];
                REG_BLUE_LAYOUT:  blue_layout_reg  <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // cursor
    assign tab_col = {1'b0, cursor_col_reg[9:3], 3'b000} + 11'd8;
    assign inc_col = {1'b0, cursor_col_reg} + 11'd1;
    assign row_inc = (cursor_row_reg == ROW_MAX) ? cursor_row_reg : cursor_row_reg + 12'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end else begin
            priority if (cmd.newline) begin
                cursor_col_reg <= '0;
                cursor_row_reg <= row_inc;
            end else if (cmd.tab) begin
                if (tab_col >= {1'b0, columns_reg}) begin
                    cursor_col_reg <= '0;
                    cursor_row_reg <= row_inc;
                end else begin
                    cursor_col_reg <= tab_col[9:0];
                end
            end else if (cmd.cursor_step) begin
                if (inc_col >= {1'b0, columns_reg}) begin
                    cursor_col_reg <= '0;
                    cursor_row_reg <= row_inc;
                end else begin
                    cursor_col_reg <= inc_col[9:0];
                end
            end else begin
                // cursor holds
            end
        end
    end

    // address arithmetic, one multiply per cycle
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg     <= s_char_code;
            code_oor_reg <= ({1'b0, s_char_code} >= 9'(FONT_CHARS));
            pix_reg      <= pix_calc;
        end
        if (cmd.mul) begin
            prod_reg <= 28'(cursor_row_reg) * 28'(line_bytes_reg);
        end
        if (cmd.base) begin
            addr_reg <= frame_base_reg + 32'(32'(prod_reg) * 32'(GLYPH_ROWS)) + cell_off;
        end else if (cmd.issue) begin
            addr_reg <= addr_reg + 32'(line_bytes_reg);
        end
    end

    // font memory, one write and one registered read port
    assign load_ok = ({1'b0, s_font_row} < 5'(GLYPH_ROWS))
                  && ({1'b0, s_char_code} < 9'(FONT_CHARS));
    assign wr_addr = {s_char_code[CW-1:0], s_font_row[RW-1:0]};
    assign rd_addr = {code_reg[CW-1:0], cmd.row[RW-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            font_mem[wr_addr] <= s_font_bits;
        end
        if (adv) begin
            mem_q <= font_mem[rd_addr];
        end
    end

    // output pipe, stalls as a whole when the output is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= cmd.issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_addr_reg  <= addr_reg;
            s1_last_reg  <= cmd.last;
            s1_oor_reg   <= code_oor_reg;
            out_addr_reg <= s1_addr_reg;
            out_bits_reg <= s1_oor_reg ? 8'd0 : mem_q;
            out_pix_reg  <= pix_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_address = out_addr_reg;
    assign m_glyph_bits  = out_bits_reg;
    assign m_pixel_value = out_pix_reg;
    assign m_last_row    = out_last_reg;

endmodule

FILE: rtl/text_console_glyph_writer_unit.sv
// top level of the text console glyph writer
// depends on tcg_pkg, tcg_ctrl and tcg_datapath

// Text console writer for a linear framebuffer with an 8-pixel-wide bitmap
// font. A load command (s_command 0) stores one font byte. A print command
// (s_command 1) acts on its character: NUL does nothing, newline and tab
// move the cursor; neither these nor a load hold the input. A printable
// character in 16 or 32 bpp mode emits GLYPH_ROWS row writes on the m_
// channel (row byte address, glyph bits MSB leftmost, packed foreground
// pixel, last-row flag) and then advances the cursor with wrap. A printed
// character holds the input while the block accepts it, does the text row
// times line stride multiply, forms the first row address, and then issues
// one glyph row per cycle while the output does not stall, a rate set by
// the single read port of the font memory. Each row is read from the font
// memory into stage one, then moves on to the output register. The font
// memory has no reset; glyphs must be loaded before they are printed.
// Configuration writes take effect at once and are meant for an idle block.

module text_console_glyph_writer_unit import tcg_pkg::*; #(
    parameter int GLYPH_ROWS = 16,
    parameter int FONT_CHARS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [7:0]           s_char_code,
    input  logic [3:0]           s_font_row,
    input  logic [7:0]           s_font_bits,
    // row writes
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_row_address,
    output logic [7:0]           m_glyph_bits,
    output logic [31:0]          m_pixel_value,
    output logic                 m_last_row
);

    // command stream from the sequencer, status back from the datapath
    tcg_cmd_t  cmd;
    tcg_stat_t stat;

    // sequencer: owns the input transfer and the glyph row counter
    tcg_ctrl #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: registers, cursor, font memory and the output pipe
    tcg_datapath #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .FONT_CHARS (FONT_CHARS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_command     (s_command),
        .s_char_code   (s_char_code),
        .s_font_row    (s_font_row),
        .s_font_bits   (s_font_bits),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_row_address (m_row_address),
        .m_glyph_bits  (m_glyph_bits),
        .m_pixel_value (m_pixel_value),
        .m_last_row    (m_last_row)
    );

endmodule

FILE: rtl/tcg_checker.sv
// port-level checks for the glyph writer, attached by bind
// depends on tcg_pkg and text_console_glyph_writer_unit

module tcg_checker import tcg_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_command,
    input logic [7:0]           s_char_code,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [31:0]          m_row_address,
    input logic [7:0]           m_glyph_bits,
    input logic [31:0]          m_pixel_value,
    input logic                 m_last_row
);

    // a held row write keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_address)
            && $stable(m_glyph_bits) && $stable(m_pixel_value) && $stable(m_last_row))
        else $error("row write changed while stalled");

    // glyph rows follow each other without a gap
    a_rows_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=> m_valid)
        else $error("gap inside a glyph");

    // a font load completes in the cycle of its transfer
    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_command |=> s_ready)
        else $error("font load held the input");

    // a NUL print does not hold the input
    a_nul_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command && (s_char_code == CH_NUL) |=> s_ready)
        else $error("NUL held the input");

endmodule

bind text_console_glyph_writer_unit tcg_checker u_tcg_checker (.*);

FILE: bench/text_console_glyph_writer_unit_tb.sv
// self-checking bench for the text console glyph writer unit
// predicts every row write from its own copy of cursor, font and settings
// depends on tcg_pkg and text_console_glyph_writer_unit
`timescale 1ns / 1ps

module text_console_glyph_writer_unit_tb;
    import tcg_pkg::*;

    localparam int GLYPH_ROWS    = 16;
    localparam int FONT_CHARS    = 256;
    // margin for a printed glyph to drain from the block
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic       CMD_LOAD  = 1'b0;
    localparam logic       CMD_PRINT = 1'b1;
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct {
        logic       cmd;
        logic [7:0] code;
        logic [3:0] frow;
        logic [7:0] fbits;
    } console_item_t;

    typedef struct {
        logic [31:0] addr;
        logic [7:0]  bits;
        logic [31:0] pixel;
        logic        last;
    } row_write_t;

    // block ports, all known from time zero
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_command   = 1'b0;
    logic [7:0]           s_char_code = '0;
    logic [3:0]           s_font_row  = '0;
    logic [7:0]           s_font_bits = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [31:0]          m_row_address;
    logic [7:0]           m_glyph_bits;
    logic [31:0]          m_pixel_value;
    logic                 m_last_row;

    // items waiting for the driver, and row writes the block still owes
    console_item_t pending_items[$];
    row_write_t    row_writes_due[$];

    // predicted console state
    logic [31:0] cfg_frame_base = '0;
    logic [15:0] cfg_line_bytes = '0;
    logic [9:0]  cfg_columns    = COLUMNS_RESET;
    logic [1:0]  cfg_mode       = MODE_OFF;
    logic [8:0]  cfg_layout [3] = '{default: '0};
    logic [7:0]  font_model [GLYPH_ROWS*FONT_CHARS];
    logic [9:0]  cur_col        = '0;
    logic [11:0] cur_row        = '0;

    // stimulus bookkeeping
    bit glyph_ready [FONT_CHARS];
    int items_queued   = 0;
    int accepted_count = 0;
    int errors         = 0;
    int cycle_count    = 0;
    bit quiet          = 1'b0;   // no idling on either side
    int hold_token     = 0;      // bumped to ask for one long receiver hold-off
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_left     = 0;
    int send_gap       = 0;
    bit item_taken     = 1'b0;   // input transfer at the last rising edge

    text_console_glyph_writer_unit #(
        .GLYPH_ROWS(GLYPH_ROWS),
        .FONT_CHARS(FONT_CHARS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_char_code   (s_char_code),
        .s_font_row    (s_font_row),
        .s_font_bits   (s_font_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_address (m_row_address),
        .m_glyph_bits  (m_glyph_bits),
        .m_pixel_value (m_pixel_value),
        .m_last_row    (m_last_row)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // one colour channel of the grey foreground, before width masking
    function automatic logic [63:0] channel_bits(input logic [8:0] layout, input logic wide);
        int unsigned size;
        size = layout[8:5];
        if (size > 8) size = 8;   // 16 bpp masks clamp at eight bits
        if (wide) return 64'(FG_LEVEL) << layout[4:0];
        return (64'(FG_LEVEL) >> (8 - size)) << layout[4:0];
    endfunction

    // column 0 of the next text row, row count sticks at its top
    task automatic next_text_row();
        cur_col = '0;
        if (cur_row < ROW_MAX) cur_row = cur_row + 12'd1;
    endtask

    task automatic console_step(input console_item_t it);
        logic [63:0] packed_fg;
        logic [31:0] cell_bytes;
        logic [31:0] addr;
        logic [10:0] tab_stop;
        logic        wide;
        row_write_t  w;
        if (it.cmd == CMD_LOAD) begin
            font_model[it.code * GLYPH_ROWS + it.frow] = it.fbits;
        end else if (it.code == CH_NUL) begin
            // prints nothing, cursor stays
        end else if (it.code == CH_NEWLINE) begin
            next_text_row();
        end else if (it.code == CH_TAB) begin
            tab_stop = {1'b0, cur_col[9:3], 3'b000} + 11'd8;
            if (tab_stop >= {1'b0, cfg_columns}) next_text_row();
            else cur_col = tab_stop[9:0];
        end else if (cfg_mode == MODE_16BPP || cfg_mode == MODE_32BPP) begin
            wide      = (cfg_mode == MODE_32BPP);
            packed_fg = channel_bits(cfg_layout[0], wide) | channel_bits(cfg_layout[1], wide)
                      | channel_bits(cfg_layout[2], wide);
            cell_bytes = wide ? 32'd32 : 32'd16;
            w.pixel    = wide ? packed_fg[31:0] : {16'h0000, packed_fg[15:0]};
            // all terms 32 bits wide so the address wraps like the hardware
            addr = cfg_frame_base + 32'(cur_row) * 32'(cfg_line_bytes) * 32'(GLYPH_ROWS)
                 + 32'(cur_col) * cell_bytes;
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                w.addr = addr;
                w.bits = font_model[it.code * GLYPH_ROWS + r];
                w.last = (r == GLYPH_ROWS - 1);
                row_writes_due.push_back(w);
                addr = addr + 32'(cfg_line_bytes);
            end
            // advance with wrap at the column count
            if ({1'b0, cur_col} + 11'd1 >= {1'b0, cfg_columns}) next_text_row();
            else cur_col = cur_col + 10'd1;
        end
        // printable character with drawing off: no writes, cursor stays
    endtask

    // ---------------------------------------------------------------
    // driver: one item per transfer, inputs move on the falling edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        console_item_t next_item;
        if (aresetn && (!s_valid || item_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 9) == 0) begin
                // random idle burst, input valid held low
                send_gap <= $urandom_range(0, 11);
                s_valid  <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item   = pending_items.pop_front();
                s_valid     <= 1'b1;
                s_command   <= next_item.cmd;
                s_char_code <= next_item.code;
                s_font_row  <= next_item.frow;
                s_font_bits <= next_item.fbits;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver ready: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: predict on each input transfer, check each row write
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: row write %s mismatch: expected %h, actual %h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        console_item_t seen;
        row_write_t    want;
        if (!aresetn) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                seen.cmd   = s_command;
                seen.code  = s_char_code;
                seen.frow  = s_font_row;
                seen.fbits = s_font_bits;
                accepted_count++;
                console_step(seen);
            end
            if (m_valid && m_ready) begin
                if (row_writes_due.size() == 0) begin
                    $display("%0t: unexpected row write: expected none, actual address %h",
                             $time, m_row_address);
                    errors++;
                end else begin
                    want = row_writes_due.pop_front();
                    check_field("address", want.addr, m_row_address);
                    check_field("glyph bits", 32'(want.bits), 32'(m_glyph_bits));
                    check_field("pixel value", want.pixel, m_pixel_value);
                    check_field("last row", 32'(want.last), 32'(m_last_row));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_glyph_writer_unit_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic queue_item(input logic cmd, input logic [7:0] code,
                              input logic [3:0] frow, input logic [7:0] fbits);
        console_item_t it;
        it.cmd   = cmd;
        it.code  = code;
        it.frow  = frow;
        it.fbits = fbits;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // all glyph rows of one character with random bitmaps
    task automatic queue_glyph(input logic [7:0] code);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            queue_item(CMD_LOAD, code, 4'(r), 8'($urandom));
        end
        glyph_ready[code] = 1'b1;
    endtask

    // print, loading the glyph first so no unwritten font entry is read
    task automatic queue_print(input logic [7:0] code);
        if (code != CH_NUL && code != CH_TAB && code != CH_NEWLINE && !glyph_ready[code]) begin
            queue_glyph(code);
        end
        queue_item(CMD_PRINT, code, 4'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FRAME_BASE:   cfg_frame_base = val;
            REG_LINE_BYTES:   cfg_line_bytes = val[15:0];
            REG_COLUMNS:      cfg_columns    = val[9:0];
            REG_PIXEL_MODE:   cfg_mode       = val[1:0];
            REG_RED_LAYOUT:   cfg_layout[0]  = val[8:0];
            REG_GREEN_LAYOUT: cfg_layout[1]  = val[8:0];
            REG_BLUE_LAYOUT:  cfg_layout[2]  = val[8:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // every input transfer done, every row write seen, block drained
    task automatic wait_idle();
        @(negedge aclk);
        while (accepted_count != items_queued || row_writes_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] random_layout();
        case ($urandom_range(0, 5))
            0:       return 32'h000;
            1:       return 32'h1ff;
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    task automatic random_config(input bit allow_off);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = 32'h0000_0000;
            1:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        write_reg(REG_FRAME_BASE, v);
        case ($urandom_range(0, 3))
            0:       v = 32'd0;
            1:       v = 32'hffff;
            2:       v = $urandom_range(1, 4096);
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(REG_LINE_BYTES, v);
        case ($urandom_range(0, 3))
            0:       v = 32'd1;
            1:       v = 32'd512;
            2:       v = $urandom_range(2, 12);   // narrow rows wrap often
            default: v = $urandom_range(1, 512);
        endcase
        write_reg(REG_COLUMNS, v);
        v = $urandom_range(0, 19);
        if (allow_off && v == 0) v = 32'(MODE_OFF);
        else if (allow_off && v == 1) v = 32'(MODE_RSVD);
        else v = $urandom_range(0, 1) ? 32'(MODE_32BPP) : 32'(MODE_16BPP);
        write_reg(REG_PIXEL_MODE, v);
        write_reg(REG_RED_LAYOUT, random_layout());
        write_reg(REG_GREEN_LAYOUT, random_layout());
        write_reg(REG_BLUE_LAYOUT, random_layout());
    endtask

    // mostly glyph prints over a small character set, some cursor
    // controls, and stray font loads as noise
    task automatic random_phase(input int n_items);
        int         kind;
        logic [7:0] code;
        repeat (n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                if ($urandom_range(0, 4) != 0) begin
                    code = 8'h40 + 8'($urandom_range(0, 7));
                end else begin
                    case ($urandom_range(0, 3))
                        0:       code = 8'h01;
                        1:       code = 8'h7f;
                        2:       code = 8'h80;
                        default: code = 8'hff;
                    endcase
                end
                queue_print(code);
            end else if (kind < 65) begin
                queue_print(CH_NEWLINE);
            end else if (kind < 75) begin
                queue_print(CH_TAB);
            end else if (kind < 80) begin
                queue_print(CH_NUL);
            end else begin
                queue_item(CMD_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: drawing off, 80 columns, only the cursor moves
        queue_glyph(8'h41);
        queue_glyph(8'hff);
        queue_item(CMD_LOAD, 8'hff, 4'd0, 8'hff);
        queue_item(CMD_LOAD, 8'hff, 4'd15, 8'h00);
        queue_item(CMD_LOAD, CH_NUL, 4'd15, 8'hff);
        queue_print(8'h41);
        queue_print(CH_TAB);
        queue_print(CH_NEWLINE);
        queue_print(CH_NUL);
        // ten tab stops cross the 80 column edge
        repeat (10) queue_print(CH_TAB);
        wait_idle();

        // 32 bpp, address wraps past 2^32, narrow rows, far field positions
        write_reg(REG_FRAME_BASE, 32'hffff_ff00);
        write_reg(REG_LINE_BYTES, 32'hffff);
        write_reg(REG_COLUMNS, 32'd3);
        write_reg(REG_PIXEL_MODE, 32'(MODE_32BPP));
        write_reg(REG_RED_LAYOUT, 32'h000);
        write_reg(REG_GREEN_LAYOUT, 32'h1f8);
        write_reg(REG_BLUE_LAYOUT, 32'h01f);
        @(posedge aclk);
        queue_print(8'h41);
        queue_print(8'hff);
        queue_print(8'h01);
        queue_print(CH_TAB);
        queue_print(CH_NUL);
        queue_print(CH_NEWLINE);
        queue_print(8'h41);
        queue_print(8'h41);
        wait_idle();

        // 16 bpp with full, partial and oversized masks, widest rows
        write_reg(REG_FRAME_BASE, 32'h0000_0000);
        write_reg(REG_LINE_BYTES, 32'd0);
        write_reg(REG_COLUMNS, 32'd512);
        write_reg(REG_PIXEL_MODE, 32'(MODE_16BPP));
        write_reg(REG_RED_LAYOUT, 32'h10b);
        write_reg(REG_GREEN_LAYOUT, 32'h0c5);
        write_reg(REG_BLUE_LAYOUT, 32'h1ff);
        @(posedge aclk);
        queue_print(8'h41);
        queue_print(8'hff);
        queue_print(CH_TAB);
        queue_print(8'h01);
        wait_idle();

        // undefined pixel mode draws nothing, single column row
        write_reg(REG_COLUMNS, 32'd1);
        write_reg(REG_PIXEL_MODE, 32'(MODE_RSVD));
        @(posedge aclk);
        queue_print(8'h41);
        queue_print(CH_TAB);
        queue_print(8'hff);
        queue_print(CH_NEWLINE);
        wait_idle();

        // random settings per phase; one phase gets the long hold-off
        for (int p = 0; p < 6; p++) begin
            random_config(1'b1);
            @(posedge aclk);
            random_phase(30);
            if (p == 2) hold_token++;
            wait_idle();
        end

        // drawing on for a whole phase
        random_config(1'b0);
        @(posedge aclk);
        random_phase(20);
        wait_idle();

        // closing stretch at full rate on both sides
        random_config(1'b0);
        @(posedge aclk);
        quiet = 1'b1;
        random_phase(30);
        wait_idle();

        if (errors == 0 && row_writes_due.size() == 0) begin
            $display("text_console_glyph_writer_unit_tb: clean");
        end else begin
            $display("text_console_glyph_writer_unit_tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tcg_pkg.sv
rtl/tcg_ctrl.sv
rtl/tcg_datapath.sv
rtl/text_console_glyph_writer_unit.sv
rtl/tcg_checker.sv
bench/text_console_glyph_writer_unit_tb.sv
